@@ hdl/assert_macros.svh @@
// Assertion macros for the template token scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tts_pkg.sv @@
// Types, constants and helpers for the template token scanner.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  localparam int POS_W     = 16;
  localparam int FIELD_W   = 16;
  localparam int TYPE_W    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam pos_t POS_MAX = {POS_W{1'b1}};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [TYPE_W-1:0] {
    TK_COMMENT = 3'd0,
    TK_NEWLINE = 3'd1,
    TK_CODE    = 3'd2,
    TK_TEXT    = 3'd3,
    TK_ERROR   = 3'd4,
    TK_END     = 3'd5
  } tok_type_t;

  typedef struct packed {
    tok_type_t token_type;
    field_t    token_start;
    field_t    token_length;
    field_t    start_line;
    logic      last;
  } res_t;

  function automatic pos_t sat_inc(input pos_t v);
    sat_inc = (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  function automatic pos_t span(input pos_t from, input pos_t to);
    span = (to > from) ? to - from : '0;
  endfunction

  function automatic res_t mk_res(input tok_type_t t, input pos_t start, input pos_t len,
                                  input pos_t line);
    mk_res.token_type   = t;
    mk_res.token_start  = field_t'(start);
    mk_res.token_length = field_t'(len);
    mk_res.start_line   = field_t'(line);
    mk_res.last         = 1'b0;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tts_if.sv @@
// Valid/ready channel interfaces for the scanner's input bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none

interface tts_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface tts_out_if;
  logic                 valid;
  logic                 ready;
  tts_pkg::tok_type_t   token_type;
  tts_pkg::field_t      token_start;
  tts_pkg::field_t      token_length;
  tts_pkg::field_t      start_line;
  logic                 last;

  modport source (output valid, output token_type, output token_start,
                  output token_length, output start_line, output last, input ready);
  modport sink   (input valid, input token_type, input token_start,
                  input token_length, input start_line, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/template_token_scanner.sv @@
// Template token scanner top level: byte classifier, scan state and token queue.
// One input byte is taken per clock; its tokens (zero, one or two) are decided in the
// accept cycle and written into a four-entry token queue, whose head entry drives the
// output. The input is ready while the queue holds at most two tokens, so with the output
// always ready a byte that yields at most one token passes every cycle; a byte that yields
// two (a delimiter that ends a token and is a newline itself, or end of input with a
// pending text or comment token) sends both through the single output port, and a long
// run of such bytes is paced by that port. Offsets and line numbers saturate at their
// maximum; end of input returns the scan state, offset and line counters to reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module template_token_scanner (
  input  wire logic         clk,
  input  wire logic         rst_n,
  tts_in_if.sink            in_chan,
  tts_out_if.source         out_chan
);

  typedef enum logic [4:0] {
    MODE_IDLE      = 5'b00001,
    MODE_TEXT      = 5'b00010,
    MODE_COMMENT   = 5'b00100,
    MODE_CODE_LEAD = 5'b01000,
    MODE_CODE_BODY = 5'b10000
  } mode_t;

  mode_t           mode_r, mode_nxt, mode_mid;
  tts_pkg::pos_t   pos_r, pos_nxt;
  tts_pkg::pos_t   line_r, line_nxt;
  tts_pkg::pos_t   tstart_r, tstart_nxt;
  tts_pkg::pos_t   tend_r, tend_nxt;
  tts_pkg::pos_t   tline_r, tline_nxt;

  tts_pkg::res_t   fifo_r [tts_pkg::FIFO_DEPTH];
  tts_pkg::ptr_t   head_r, head_nxt;
  tts_pkg::ptr_t   tail_r, tail_nxt;
  tts_pkg::cnt_t   cnt_r, cnt_nxt;

  logic            in_acc, pop, consumed;
  logic            emit_a, emit_b;
  tts_pkg::res_t   res_a, res_b, res0, res1;
  logic [1:0]      n_res;
  logic [7:0]      c;
  logic            is_blank, is_nl, is_hash, is_at, is_text;
  logic            end_acc, q_over, at_reset_state;

  assign in_chan.ready = (cnt_r <= tts_pkg::cnt_t'(tts_pkg::FIFO_DEPTH - 2));
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign pop           = out_chan.valid && out_chan.ready;

  assign c        = in_chan.data_byte;
  assign is_blank = (c == tts_pkg::CH_SPACE) || (c == tts_pkg::CH_TAB);
  assign is_nl    = (c == tts_pkg::CH_NL);
  assign is_hash  = (c == tts_pkg::CH_HASH);
  assign is_at    = (c == tts_pkg::CH_AT);
  assign is_text  = !is_blank && !is_nl && !is_hash;

  always_comb begin
    mode_nxt   = mode_r;
    mode_mid   = mode_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    tstart_nxt = tstart_r;
    tend_nxt   = tend_r;
    tline_nxt  = tline_r;
    emit_a     = 1'b0;
    emit_b     = 1'b0;
    consumed   = 1'b0;
    res_a      = '0;
    res_b      = '0;
    if (in_acc) begin
      if (in_chan.command == tts_pkg::CMD_END) begin
        if (mode_r == MODE_TEXT) begin
          emit_a = 1'b1;
          res_a  = tts_pkg::mk_res(tts_pkg::TK_TEXT, tstart_r,
                                   tts_pkg::span(tstart_r, pos_r), tline_r);
        end else if (mode_r == MODE_COMMENT) begin
          emit_a = 1'b1;
          res_a  = tts_pkg::mk_res(tts_pkg::TK_COMMENT, tstart_r,
                                   tts_pkg::span(tstart_r, pos_r), tline_r);
        end
        emit_b = 1'b1;
        if (mode_r == MODE_CODE_LEAD || mode_r == MODE_CODE_BODY) begin
          res_b = tts_pkg::mk_res(tts_pkg::TK_ERROR, pos_r, '0, line_r);
        end else begin
          res_b = tts_pkg::mk_res(tts_pkg::TK_END, pos_r, '0, line_r);
        end
        mode_nxt   = MODE_IDLE;
        pos_nxt    = '0;
        line_nxt   = tts_pkg::pos_t'(1);
        tstart_nxt = '0;
        tend_nxt   = '0;
        tline_nxt  = tts_pkg::pos_t'(1);
      end else begin
        case (mode_r)
          MODE_TEXT: begin
            if (!is_text) begin
              emit_a   = 1'b1;
              res_a    = tts_pkg::mk_res(tts_pkg::TK_TEXT, tstart_r,
                                         tts_pkg::span(tstart_r, pos_r), tline_r);
              mode_mid = MODE_IDLE;
            end
          end
          MODE_COMMENT: begin
            if (is_nl) begin
              emit_a   = 1'b1;
              res_a    = tts_pkg::mk_res(tts_pkg::TK_COMMENT, tstart_r,
                                         tts_pkg::span(tstart_r, pos_r), tline_r);
              mode_mid = MODE_IDLE;
            end
          end
          MODE_CODE_LEAD: begin
            if (is_at) begin
              emit_a   = 1'b1;
              res_a    = tts_pkg::mk_res(tts_pkg::TK_CODE, pos_r, '0, line_r);
              mode_mid = MODE_IDLE;
              consumed = 1'b1;
            end else if (!is_blank && !is_nl) begin
              tstart_nxt = pos_r;
              tend_nxt   = tts_pkg::sat_inc(pos_r);
              tline_nxt  = line_r;
              mode_mid   = MODE_CODE_BODY;
            end
          end
          MODE_CODE_BODY: begin
            if (is_at) begin
              emit_a   = 1'b1;
              res_a    = tts_pkg::mk_res(tts_pkg::TK_CODE, tstart_r,
                                         tts_pkg::span(tstart_r, tend_r), tline_r);
              mode_mid = MODE_IDLE;
              consumed = 1'b1;
            end else if (!is_blank && !is_nl) begin
              tend_nxt = tts_pkg::sat_inc(pos_r);
            end
          end
          default: mode_mid = MODE_IDLE;
        endcase
        mode_nxt = mode_mid;
        if (mode_mid == MODE_IDLE && !consumed) begin
          if (is_hash) begin
            mode_nxt   = MODE_COMMENT;
            tstart_nxt = tts_pkg::sat_inc(pos_r);
            tline_nxt  = line_r;
          end else if (is_nl) begin
            emit_b = 1'b1;
            res_b  = tts_pkg::mk_res(tts_pkg::TK_NEWLINE, pos_r, '0, line_r);
          end else if (is_at) begin
            mode_nxt = MODE_CODE_LEAD;
          end else if (!is_blank) begin
            mode_nxt   = MODE_TEXT;
            tstart_nxt = pos_r;
            tline_nxt  = line_r;
          end
        end
        if (is_nl) begin
          line_nxt = tts_pkg::sat_inc(line_r);
        end
        pos_nxt = tts_pkg::sat_inc(pos_r);
      end
    end
  end

  // pack the item's tokens in order and mark the final one
  always_comb begin
    res0  = res_a;
    res1  = res_b;
    n_res = 2'd0;
    if (emit_a && emit_b) begin
      res1.last = 1'b1;
      n_res     = 2'd2;
    end else if (emit_a) begin
      res0.last = 1'b1;
      n_res     = 2'd1;
    end else if (emit_b) begin
      res0      = res_b;
      res0.last = 1'b1;
      n_res     = 2'd1;
    end
  end

  assign head_nxt = head_r + tts_pkg::ptr_t'(pop);
  assign tail_nxt = tail_r + tts_pkg::ptr_t'(n_res);
  assign cnt_nxt  = cnt_r + tts_pkg::cnt_t'(n_res) - tts_pkg::cnt_t'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      line_r   <= tts_pkg::pos_t'(1);
      tstart_r <= '0;
      tend_r   <= '0;
      tline_r  <= tts_pkg::pos_t'(1);
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      tstart_r <= tstart_nxt;
      tend_r   <= tend_nxt;
      tline_r  <= tline_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      fifo_r[tail_r] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo_r[tail_r + tts_pkg::ptr_t'(1)] <= res1;
    end
  end

  assign out_chan.valid        = (cnt_r != '0);
  assign out_chan.token_type   = fifo_r[head_r].token_type;
  assign out_chan.token_start  = fifo_r[head_r].token_start;
  assign out_chan.token_length = fifo_r[head_r].token_length;
  assign out_chan.start_line   = fifo_r[head_r].start_line;
  assign out_chan.last         = fifo_r[head_r].last;

  assign end_acc        = in_acc && (in_chan.command == tts_pkg::CMD_END);
  assign q_over         = (cnt_r > tts_pkg::cnt_t'(tts_pkg::FIFO_DEPTH));
  assign at_reset_state = (mode_r == MODE_IDLE) && (pos_r == '0) &&
                          (line_r == tts_pkg::pos_t'(1));

  `ASSERT_ALWAYS(a_queue_bound, !q_over, "token queue overflow")
  `ASSERT_NEXT(a_end_clears, end_acc, at_reset_state, "end of input did not clear state")
  `ASSERT_NEXT(a_end_emits, end_acc, cnt_r != '0, "end of input produced no token")
  `ASSERT_NEXT(a_pos_mono, !end_acc, pos_r >= $past(pos_r), "byte position went backward")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the template token scanner: byte stimulus, token predictor, checker.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [4:0] {
    SCAN_IDLE      = 5'b00001,
    SCAN_TEXT      = 5'b00010,
    SCAN_COMMENT   = 5'b00100,
    SCAN_CODE_LEAD = 5'b01000,
    SCAN_CODE_BODY = 5'b10000
  } scan_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  tts_in_if  in_chan();
  tts_out_if out_chan();

  template_token_scanner u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predictor state
  scan_mode_t      mode;
  tts_pkg::pos_t   cur_pos;
  tts_pkg::pos_t   cur_line;
  tts_pkg::pos_t   tok_begin;
  tts_pkg::pos_t   code_end;
  tts_pkg::pos_t   tok_line;
  tts_pkg::res_t   step_tokens[2];
  int              step_count;

  tts_pkg::res_t expected_tokens[$];
  int   err_count = 0;
  int   accepted_items = 0;
  bit   idle_en = 1'b1;
  int   hold_req = 0;

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic tts_pkg::pos_t bump_sat(input tts_pkg::pos_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic tts_pkg::pos_t run_length(input tts_pkg::pos_t from,
                                               input tts_pkg::pos_t upto);
    return (upto > from) ? upto - from : '0;
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b,
                                                  input logic [7:0] c, input logic [7:0] d);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == a || v == b || v == c || v == d);
    return v;
  endfunction

  task automatic clear_scan_state();
    mode      = SCAN_IDLE;
    cur_pos   = '0;
    cur_line  = tts_pkg::pos_t'(1);
    tok_begin = '0;
    code_end  = '0;
    tok_line  = tts_pkg::pos_t'(1);
  endtask

  task automatic add_token(input tts_pkg::tok_type_t t, input tts_pkg::pos_t s,
                           input tts_pkg::pos_t len, input tts_pkg::pos_t ln);
    step_tokens[step_count].token_type   = t;
    step_tokens[step_count].token_start  = tts_pkg::field_t'(s);
    step_tokens[step_count].token_length = tts_pkg::field_t'(len);
    step_tokens[step_count].start_line   = tts_pkg::field_t'(ln);
    step_tokens[step_count].last         = 1'b0;
    step_count++;
  endtask

  task automatic predict_tokens(input logic cmd, input logic [7:0] c);
    bit used;
    bit blank;
    used = 1'b0;
    blank = (c == tts_pkg::CH_SPACE || c == tts_pkg::CH_TAB);
    step_count = 0;
    if (cmd == tts_pkg::CMD_END) begin
      if (mode == SCAN_TEXT)
        add_token(tts_pkg::TK_TEXT, tok_begin, run_length(tok_begin, cur_pos), tok_line);
      else if (mode == SCAN_COMMENT)
        add_token(tts_pkg::TK_COMMENT, tok_begin, run_length(tok_begin, cur_pos), tok_line);
      if (mode == SCAN_CODE_LEAD || mode == SCAN_CODE_BODY)
        add_token(tts_pkg::TK_ERROR, cur_pos, '0, cur_line);
      else
        add_token(tts_pkg::TK_END, cur_pos, '0, cur_line);
      clear_scan_state();
    end else begin
      case (mode)
        SCAN_TEXT: begin
          if (blank || c == tts_pkg::CH_NL || c == tts_pkg::CH_HASH) begin
            add_token(tts_pkg::TK_TEXT, tok_begin, run_length(tok_begin, cur_pos), tok_line);
            mode = SCAN_IDLE;
          end
        end
        SCAN_COMMENT: begin
          if (c == tts_pkg::CH_NL) begin
            add_token(tts_pkg::TK_COMMENT, tok_begin, run_length(tok_begin, cur_pos),
                      tok_line);
            mode = SCAN_IDLE;
          end
        end
        SCAN_CODE_LEAD: begin
          if (c == tts_pkg::CH_AT) begin
            add_token(tts_pkg::TK_CODE, cur_pos, '0, cur_line);
            mode = SCAN_IDLE;
            used = 1'b1;
          end else if (!blank && c != tts_pkg::CH_NL) begin
            tok_begin = cur_pos;
            code_end  = bump_sat(cur_pos);
            tok_line  = cur_line;
            mode      = SCAN_CODE_BODY;
          end
        end
        SCAN_CODE_BODY: begin
          if (c == tts_pkg::CH_AT) begin
            add_token(tts_pkg::TK_CODE, tok_begin, run_length(tok_begin, code_end), tok_line);
            mode = SCAN_IDLE;
            used = 1'b1;
          end else if (!blank && c != tts_pkg::CH_NL) begin
            code_end = bump_sat(cur_pos);
          end
        end
        default: mode = SCAN_IDLE;
      endcase
      if (mode == SCAN_IDLE && !used) begin
        if (c == tts_pkg::CH_HASH) begin
          mode      = SCAN_COMMENT;
          tok_begin = bump_sat(cur_pos);
          tok_line  = cur_line;
        end else if (c == tts_pkg::CH_NL) begin
          add_token(tts_pkg::TK_NEWLINE, cur_pos, '0, cur_line);
        end else if (c == tts_pkg::CH_AT) begin
          mode = SCAN_CODE_LEAD;
        end else if (!blank) begin
          mode      = SCAN_TEXT;
          tok_begin = cur_pos;
          tok_line  = cur_line;
        end
      end
      if (c == tts_pkg::CH_NL) cur_line = bump_sat(cur_line);
      cur_pos = bump_sat(cur_pos);
    end
    for (int i = 0; i < step_count; i++) begin
      if (i == step_count - 1) step_tokens[i].last = 1'b1;
      expected_tokens.push_back(step_tokens[i]);
    end
  endtask

  // valid stays high when the next call follows in the same step
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.command   <= cmd;
    in_chan.data_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    accepted_items++;
    predict_tokens(cmd, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(tts_pkg::CMD_DATA, s[i]);
  endtask

  task automatic send_end();
    send_item(tts_pkg::CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drain(input int settle);
    in_chan.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic check_token();
    tts_pkg::res_t exp_tok;
    if (expected_tokens.size() == 0) begin
      note_mismatch($sformatf("unexpected token type %0d start %0d",
                              out_chan.token_type, out_chan.token_start));
      return;
    end
    exp_tok = expected_tokens.pop_front();
    if (out_chan.token_type !== exp_tok.token_type)
      note_mismatch($sformatf("token_type %0d, expected %0d",
                              out_chan.token_type, exp_tok.token_type));
    if (out_chan.token_start !== exp_tok.token_start)
      note_mismatch($sformatf("token_start %0d, expected %0d",
                              out_chan.token_start, exp_tok.token_start));
    if (out_chan.token_length !== exp_tok.token_length)
      note_mismatch($sformatf("token_length %0d, expected %0d",
                              out_chan.token_length, exp_tok.token_length));
    if (out_chan.start_line !== exp_tok.start_line)
      note_mismatch($sformatf("start_line %0d, expected %0d",
                              out_chan.start_line, exp_tok.start_line));
    if (out_chan.last !== exp_tok.last)
      note_mismatch($sformatf("last %0b, expected %0b", out_chan.last, exp_tok.last));
  endtask

  // token sink: checks each accepted token, stalls at random, honors long holds
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) check_token();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_end();
    send_item(tts_pkg::CMD_DATA, 8'h00);
    send_text("\t#c\n");
    send_end();
    send_text("@\nx \t@@@");
    send_item(tts_pkg::CMD_DATA, 8'hFF);
    send_text("@");
    send_end();
    send_text("#z");
    send_end();
    send_text("@ ");
    send_end();
    wait_drain(4);
  endtask

  task automatic test_backpressure();
    hold_req = 100;
    repeat (15) send_text("w\n");
    send_end();
    wait_drain(4);
  endtask

  task automatic test_random(input int n_items);
    int first;
    int len;
    first = accepted_items;
    while (accepted_items - first < n_items) begin
      if (accepted_items - first > n_items - 300) idle_en = 1'b0;
      case ($urandom_range(0, 19))
        2, 3, 4, 5, 6, 18: begin
          len = $urandom_range(1, 6);
          repeat (len)
            send_item(tts_pkg::CMD_DATA,
                      rand_byte_except(tts_pkg::CH_SPACE, tts_pkg::CH_TAB,
                                       tts_pkg::CH_NL, tts_pkg::CH_HASH));
          case ($urandom_range(0, 2))
            0: send_item(tts_pkg::CMD_DATA,
                         $urandom_range(0, 1) ? tts_pkg::CH_SPACE : tts_pkg::CH_TAB);
            1: send_item(tts_pkg::CMD_DATA, tts_pkg::CH_NL);
            default: ;
          endcase
        end
        7, 8: begin
          len = $urandom_range(1, 3);
          repeat (len)
            send_item(tts_pkg::CMD_DATA,
                      $urandom_range(0, 1) ? tts_pkg::CH_SPACE : tts_pkg::CH_TAB);
        end
        9, 10: begin
          send_item(tts_pkg::CMD_DATA, tts_pkg::CH_HASH);
          len = $urandom_range(0, 6);
          repeat (len)
            send_item(tts_pkg::CMD_DATA,
                      rand_byte_except(tts_pkg::CH_NL, tts_pkg::CH_NL,
                                       tts_pkg::CH_NL, tts_pkg::CH_NL));
          send_item(tts_pkg::CMD_DATA, tts_pkg::CH_NL);
        end
        11, 12: send_item(tts_pkg::CMD_DATA, tts_pkg::CH_NL);
        13, 14, 15, 16: begin
          send_item(tts_pkg::CMD_DATA, tts_pkg::CH_AT);
          for (int part = 0; part < 3; part++) begin
            len = (part == 1) ? $urandom_range(0, 5) : $urandom_range(0, 2);
            repeat (len) begin
              if (part == 1)
                send_item(tts_pkg::CMD_DATA,
                          rand_byte_except(tts_pkg::CH_AT, tts_pkg::CH_AT,
                                           tts_pkg::CH_AT, tts_pkg::CH_AT));
              else
                case ($urandom_range(0, 2))
                  0: send_item(tts_pkg::CMD_DATA, tts_pkg::CH_SPACE);
                  1: send_item(tts_pkg::CMD_DATA, tts_pkg::CH_TAB);
                  default: send_item(tts_pkg::CMD_DATA, tts_pkg::CH_NL);
                endcase
            end
          end
          if ($urandom_range(0, 7) != 0) send_item(tts_pkg::CMD_DATA, tts_pkg::CH_AT);
        end
        17: send_end();
        default: begin
          len = $urandom_range(1, 8);
          repeat (len) send_item(tts_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        end
      endcase
    end
    send_end();
    wait_drain(8);
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.command   <= tts_pkg::CMD_DATA;
    in_chan.data_byte <= 8'h00;
    clear_scan_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1790);
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tts_pkg.sv
hdl/tts_if.sv
hdl/template_token_scanner.sv
test/tb_top.sv
